// File: rtl/bbcd_pkg.sv
// -----------------------------------------------------------------------------
// bbcd_pkg
// Shared types and constants for the byte budget cache directory.
// -----------------------------------------------------------------------------
package bbcd_pkg;

   localparam int NUM_SLOTS     = 16;
   localparam int SLOT_W        = $clog2(NUM_SLOTS);
   localparam int CNT_W         = $clog2(NUM_SLOTS + 1);
   localparam int RUN_THRESHOLD = 3;
   localparam int STEP_W        = 4;

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_PUT    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   localparam logic [1:0] KIND_FINAL = 2'd0;
   localparam logic [1:0] KIND_EVICT = 2'd1;
   localparam logic [1:0] KIND_AHEAD = 2'd2;

   localparam logic [1:0] POL_LRU   = 2'd0;
   localparam logic [1:0] POL_LFU   = 2'd1;
   localparam logic [1:0] POL_ADAPT = 2'd2;

   localparam logic [1:0] CSR_POLICY   = 2'd0;
   localparam logic [1:0] CSR_BUDGET   = 2'd1;
   localparam logic [1:0] CSR_RA_ON    = 2'd2;
   localparam logic [1:0] CSR_RA_DEPTH = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic       accept;
      logic       find;
      logic       op_exec;
      logic       scan_init;
      logic       scan_step;
      logic       evict;
      logic       insert;
      logic       emit;
      logic [1:0] emit_kind;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   found;
      logic   bytes_zero;
      logic   ra_go;
      logic   ra_done;
      logic   evict_need;
      logic   scan_last;
      logic   out_free;
   } status_type;

endpackage

// File: rtl/byte_budget_cache_directory_core.sv
// -----------------------------------------------------------------------------
// byte_budget_cache_directory_core
// Sixteen-entry sized directory with byte budget and LRU/LFU/adaptive eviction.
// -----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): operation, entry_key, entry_bytes. One request
//   is in flight at a time; req_stall stays high until its final response has
//   been loaded into the output register.
//   Response channel (rsp_*): zero or more eviction notices or read-ahead
//   suggestions, then one final response with rsp_last set.
//   Configuration (csr_*): write while idle; takes effect on the next request.
// Sequence:
//   A lookup, update, remove or clear steps the sequencer through accept,
//   lookup, execute and emit, and emit loads the final response into the
//   output register. A put that inserts adds a budget check and an insert.
//   Each read-ahead suggestion adds an emit step. Each eviction adds a
//   budget check, a walk over all sixteen positions of the recency order
//   through the single table read port to find the victim, then update and
//   emit.
// Reset: the table empties, counters clear, recency order returns to identity
//   and the configuration, scan, sequencer and result-valid registers reset.
// Stall: a valid output register holds while rsp_stall is high and the
//   sequencer waits at its next emission.
// -----------------------------------------------------------------------------
module byte_budget_cache_directory_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_entry_key,
   input  logic [31:0] req_entry_bytes,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [35:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [63:0] rsp_result_id,
   output logic        rsp_hit,
   output logic [35:0] rsp_used_total,
   output logic [4:0]  rsp_entry_total,
   output logic [47:0] rsp_hit_total,
   output logic [47:0] rsp_miss_total,
   output logic [47:0] rsp_eviction_total,
   output logic [47:0] rsp_access_total,
   output logic        rsp_last
);

   bbcd_pkg::cmd_type    cmd;
   bbcd_pkg::status_type status;

   bbcd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bbcd_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_entry_key      (req_entry_key),
      .req_entry_bytes    (req_entry_bytes),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_result_id      (rsp_result_id),
      .rsp_hit            (rsp_hit),
      .rsp_used_total     (rsp_used_total),
      .rsp_entry_total    (rsp_entry_total),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .rsp_access_total   (rsp_access_total),
      .rsp_last           (rsp_last)
   );

   // entry count never exceeds the table size
   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_total <= bbcd_pkg::CNT_W'(bbcd_pkg::NUM_SLOTS)))
      else $error("entry count above table size");

   // only final responses carry hit or last
   a_side_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != bbcd_pkg::KIND_FINAL) |-> (!rsp_hit && !rsp_last))
      else $error("notice carries hit or last");

   // last is set only on a final response
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_kind == bbcd_pkg::KIND_FINAL))
      else $error("last on a non-final response");

   // no new request is taken while a response is still pending in the sequence
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

endmodule

// File: rtl/bbcd_datapath.sv
// -----------------------------------------------------------------------------
// bbcd_datapath
// Slot table, recency order, counters, victim scan and result register.
// -----------------------------------------------------------------------------
module bbcd_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  bbcd_pkg::cmd_type           cmd,
   output bbcd_pkg::status_type        status,
   input  logic [1:0]                  req_operation,
   input  logic [63:0]                 req_entry_key,
   input  logic [31:0]                 req_entry_bytes,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [35:0]                 csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_kind,
   output logic [63:0]                 rsp_result_id,
   output logic                        rsp_hit,
   output logic [35:0]                 rsp_used_total,
   output logic [4:0]                  rsp_entry_total,
   output logic [47:0]                 rsp_hit_total,
   output logic [47:0]                 rsp_miss_total,
   output logic [47:0]                 rsp_eviction_total,
   output logic [47:0]                 rsp_access_total,
   output logic                        rsp_last
);

   localparam int N  = bbcd_pkg::NUM_SLOTS;
   localparam int SW = bbcd_pkg::SLOT_W;

   function automatic logic [47:0] sat48(input logic [47:0] v);
      return (&v) ? v : v + 48'd1;
   endfunction

   // configuration registers
   logic [1:0]  policy_ff;
   logic [35:0] budget_ff;
   logic        ra_on_ff;
   logic [3:0]  ra_depth_ff;

   // request latch
   bbcd_pkg::op_type op_ff;
   logic [63:0] key_ff;
   logic [31:0] bytes_ff;
   logic        found_ff;
   logic [SW-1:0] idx_ff;

   // slot table
   logic          valid_ff [N];
   logic [63:0]   key_mem  [N];
   logic [31:0]   size_mem [N];
   logic [31:0]   uses_mem [N];
   logic [SW-1:0] order_ff [N];

   logic [35:0] held_ff;
   logic [47:0] hits_ff, misses_ff, evicts_ff, access_ff;

   // scan state
   logic [SW-1:0]  ptr_ff, lru_ff, lfu_ff;
   logic           lfu_have_ff;
   logic [31:0]    best_uses_ff;
   logic           run_have_ff, run_brk_ff;
   logic [63:0]    run_prev_ff;
   logic [bbcd_pkg::STEP_W-1:0] run_steps_ff;

   logic [63:0] victim_key_ff;
   logic [3:0]  ra_cnt_ff;

   // result register
   logic        out_valid_ff;
   logic [1:0]  out_kind_ff;
   logic [63:0] out_id_ff;
   logic        out_hit_ff, out_last_ff;
   logic [35:0] out_used_ff;
   logic [4:0]  out_cnt_ff;
   logic [47:0] out_hits_ff, out_misses_ff, out_evicts_ff, out_access_ff;

   // combinational helpers
   logic [N-1:0]  match;
   logic          match_any;
   logic [SW-1:0] match_idx;
   logic [bbcd_pkg::CNT_W-1:0] cnt;
   logic [SW-1:0] free_slot;
   logic [SW-1:0] victim;
   logic [SW-1:0] rd_slot;
   logic [63:0]   rd_key;
   logic [31:0]   rd_size, rd_uses, uses_inc;
   logic          rd_valid;
   logic          touch_en;
   logic [SW-1:0] touch_slot;
   logic [N-1:0]  pos_match, shift_pos;
   logic          pos_any, acc;
   logic          out_free, out_load;
   logic [36:0]   need_sum;

   // parallel key compare and first-match encode
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = 0; i < N; i++) begin
         match[i] = valid_ff[i] && (key_mem[i] == key_ff);
      end
      for (int i = N - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_any = 1'b1;
            match_idx = SW'(i);
         end
      end
   end

   // occupancy and first free slot
   always_comb begin
      cnt       = '0;
      free_slot = SW'(N - 1);
      for (int i = 0; i < N; i++) begin
         cnt = cnt + bbcd_pkg::CNT_W'(valid_ff[i]);
      end
      for (int i = N - 2; i >= 0; i--) begin
         if (!valid_ff[i]) free_slot = SW'(i);
      end
   end

   // victim choice from scan results
   always_comb begin
      unique case (policy_ff)
         bbcd_pkg::POL_LFU:   victim = lfu_ff;
         bbcd_pkg::POL_ADAPT: victim = (run_steps_ff >= bbcd_pkg::STEP_W'(bbcd_pkg::RUN_THRESHOLD))
                                       ? lru_ff : lfu_ff;
         default:             victim = lru_ff;
      endcase
   end

   // single shared read port into the slot table
   always_comb begin
      priority if (cmd.scan_step) rd_slot = order_ff[ptr_ff];
      else if (cmd.evict)         rd_slot = victim;
      else                        rd_slot = idx_ff;
   end
   assign rd_key   = key_mem[rd_slot];
   assign rd_size  = size_mem[rd_slot];
   assign rd_uses  = uses_mem[rd_slot];
   assign rd_valid = valid_ff[rd_slot];
   assign uses_inc = (&rd_uses) ? rd_uses : rd_uses + 32'd1;

   // move-to-front of the recency order
   assign touch_en   = (cmd.op_exec && found_ff &&
                        (op_ff == bbcd_pkg::OP_GET ||
                         (op_ff == bbcd_pkg::OP_PUT && bytes_ff != '0))) || cmd.insert;
   assign touch_slot = cmd.insert ? free_slot : idx_ff;
   always_comb begin
      for (int p = 0; p < N; p++) pos_match[p] = (order_ff[p] == touch_slot);
      pos_any = |pos_match;
      acc     = 1'b0;
      for (int p = N - 1; p >= 0; p--) begin
         acc          = acc | pos_match[p];
         shift_pos[p] = acc | !pos_any;
      end
   end

   assign need_sum = {1'b0, held_ff} + {5'd0, bytes_ff};
   assign out_free = !out_valid_ff || !rsp_stall;
   assign out_load = cmd.emit && out_free;

   // status back to the controller
   always_comb begin
      status.op         = op_ff;
      status.found      = found_ff;
      status.bytes_zero = (bytes_ff == '0);
      status.ra_go      = ra_on_ff && (ra_depth_ff != '0);
      status.ra_done    = (ra_cnt_ff == ra_depth_ff);
      status.evict_need = (cnt != '0) &&
                          ((cnt == bbcd_pkg::CNT_W'(N)) || (need_sum > {1'b0, budget_ff}));
      status.scan_last  = (ptr_ff == SW'(N - 1));
      status.out_free   = out_free;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= bbcd_pkg::POL_LRU;
         budget_ff   <= 36'd1073741824;
         ra_on_ff    <= 1'b0;
         ra_depth_ff <= 4'd5;
      end else if (csr_write) begin
         unique case (csr_index)
            bbcd_pkg::CSR_POLICY:   policy_ff   <= csr_wdata[1:0];
            bbcd_pkg::CSR_BUDGET:   budget_ff   <= csr_wdata;
            bbcd_pkg::CSR_RA_ON:    ra_on_ff    <= csr_wdata[0];
            bbcd_pkg::CSR_RA_DEPTH: ra_depth_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // request latch and lookup result
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= bbcd_pkg::op_type'(req_operation);
         key_ff   <= req_entry_key;
         bytes_ff <= req_entry_bytes;
      end
      if (cmd.find) begin
         found_ff <= match_any;
         idx_ff   <= match_idx;
      end
   end

   // slot payload storage
   always_ff @(posedge clock) begin
      if (cmd.op_exec && found_ff) begin
         if (op_ff == bbcd_pkg::OP_GET) begin
            uses_mem[idx_ff] <= uses_inc;
         end else if (op_ff == bbcd_pkg::OP_PUT && bytes_ff != '0) begin
            uses_mem[idx_ff] <= uses_inc;
            size_mem[idx_ff] <= bytes_ff;
         end
      end
      if (cmd.insert) begin
         key_mem[free_slot]  <= key_ff;
         size_mem[free_slot] <= bytes_ff;
         uses_mem[free_slot] <= 32'd1;
      end
      if (cmd.evict) victim_key_ff <= rd_key;
   end

   // valid bits, recency order, byte count and counters
   always_ff @(posedge clock) begin
      if (reset || (cmd.op_exec && op_ff == bbcd_pkg::OP_CLEAR)) begin
         for (int i = 0; i < N; i++) begin
            valid_ff[i] <= 1'b0;
            order_ff[i] <= SW'(i);
         end
         held_ff   <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
         access_ff <= '0;
      end else begin
         if (touch_en) begin
            order_ff[0] <= touch_slot;
            for (int p = 1; p < N; p++) begin
               if (shift_pos[p]) order_ff[p] <= order_ff[p-1];
            end
         end
         if (cmd.op_exec) begin
            unique case (op_ff)
               bbcd_pkg::OP_GET: begin
                  access_ff <= sat48(access_ff);
                  if (found_ff) hits_ff   <= sat48(hits_ff);
                  else          misses_ff <= sat48(misses_ff);
               end
               bbcd_pkg::OP_PUT: begin
                  if (bytes_ff != '0) begin
                     access_ff <= sat48(access_ff);
                     if (found_ff) held_ff <= held_ff - {4'd0, rd_size} + {4'd0, bytes_ff};
                  end
               end
               bbcd_pkg::OP_REMOVE: begin
                  if (found_ff) begin
                     valid_ff[idx_ff] <= 1'b0;
                     held_ff          <= held_ff - {4'd0, rd_size};
                  end
               end
               default: ;
            endcase
         end
         if (cmd.evict) begin
            valid_ff[victim] <= 1'b0;
            held_ff          <= held_ff - {4'd0, rd_size};
            evicts_ff        <= sat48(evicts_ff);
         end
         if (cmd.insert) begin
            valid_ff[free_slot] <= 1'b1;
            held_ff             <= need_sum[35:0];
         end
      end
   end

   // victim scan over the recency order, one position per cycle
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_init) begin
         ptr_ff       <= '0;
         lru_ff       <= '0;
         lfu_ff       <= '0;
         lfu_have_ff  <= 1'b0;
         run_have_ff  <= 1'b0;
         run_brk_ff   <= 1'b0;
         run_steps_ff <= '0;
      end else if (cmd.scan_step) begin
         ptr_ff <= ptr_ff + SW'(1);
         if (rd_valid) begin
            lru_ff <= rd_slot;
            if (!lfu_have_ff || rd_uses < best_uses_ff) begin
               lfu_ff       <= rd_slot;
               best_uses_ff <= rd_uses;
               lfu_have_ff  <= 1'b1;
            end
            if (!run_brk_ff) begin
               if (run_have_ff && rd_key != run_prev_ff + 64'd1) begin
                  run_brk_ff <= 1'b1;
               end else begin
                  if (run_have_ff) run_steps_ff <= run_steps_ff + bbcd_pkg::STEP_W'(1);
                  run_prev_ff <= rd_key;
                  run_have_ff <= 1'b1;
               end
            end
         end
      end
   end

   // read-ahead offset
   always_ff @(posedge clock) begin
      if (cmd.op_exec) ra_cnt_ff <= 4'd1;
      else if (out_load && cmd.emit_kind == bbcd_pkg::KIND_AHEAD) ra_cnt_ff <= ra_cnt_ff + 4'd1;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff   <= cmd.emit_kind;
         out_hit_ff    <= (cmd.emit_kind == bbcd_pkg::KIND_FINAL) && found_ff;
         out_last_ff   <= (cmd.emit_kind == bbcd_pkg::KIND_FINAL);
         out_used_ff   <= held_ff;
         out_cnt_ff    <= 5'(cnt);
         out_hits_ff   <= hits_ff;
         out_misses_ff <= misses_ff;
         out_evicts_ff <= evicts_ff;
         out_access_ff <= access_ff;
         unique case (cmd.emit_kind)
            bbcd_pkg::KIND_EVICT: out_id_ff <= victim_key_ff;
            bbcd_pkg::KIND_AHEAD: out_id_ff <= key_ff + {60'd0, ra_cnt_ff};
            default:              out_id_ff <= key_ff;
         endcase
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_result_id      = out_id_ff;
   assign rsp_hit            = out_hit_ff;
   assign rsp_used_total     = out_used_ff;
   assign rsp_entry_total    = out_cnt_ff;
   assign rsp_hit_total      = out_hits_ff;
   assign rsp_miss_total     = out_misses_ff;
   assign rsp_eviction_total = out_evicts_ff;
   assign rsp_access_total   = out_access_ff;
   assign rsp_last           = out_last_ff;

endmodule

// File: rtl/bbcd_controller.sv
// -----------------------------------------------------------------------------
// bbcd_controller
// Sequencer for lookup, update, eviction loop and result emission.
// -----------------------------------------------------------------------------
module bbcd_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output bbcd_pkg::cmd_type     cmd,
   input  bbcd_pkg::status_type  status
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_FIND   = 10'b0000000010,
      S_OP     = 10'b0000000100,
      S_CHECK  = 10'b0000001000,
      S_SCAN   = 10'b0000010000,
      S_EVICT  = 10'b0000100000,
      S_EV_OUT = 10'b0001000000,
      S_INSERT = 10'b0010000000,
      S_RA_OUT = 10'b0100000000,
      S_FINAL  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = S_FIND;
         end
         S_FIND: begin
            cmd.find = 1'b1;
            state_in = S_OP;
         end
         S_OP: begin
            cmd.op_exec = 1'b1;
            priority if (status.op == bbcd_pkg::OP_GET && !status.found && status.ra_go)
               state_in = S_RA_OUT;
            else if (status.op == bbcd_pkg::OP_PUT && !status.bytes_zero && !status.found)
               state_in = S_CHECK;
            else
               state_in = S_FINAL;
         end
         S_CHECK: begin
            if (status.evict_need) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = S_EVICT;
         end
         S_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = S_EV_OUT;
         end
         S_EV_OUT: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = bbcd_pkg::KIND_EVICT;
            if (status.out_free) state_in = S_CHECK;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_FINAL;
         end
         S_RA_OUT: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = bbcd_pkg::KIND_AHEAD;
            if (status.out_free && status.ra_done) state_in = S_FINAL;
         end
         S_FINAL: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = bbcd_pkg::KIND_FINAL;
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule
